// ----- hw/rtl/kje_pkg.sv -----
// ----------------------------------------------------------------------------
// kje_pkg
// Shared types, constants and helpers for the keypad joystick emulation.
// ----------------------------------------------------------------------------
package kje_pkg;

  // Field widths
  localparam int KeyW   = 4;
  localparam int TypeW  = 3;
  localparam int TrimW  = 8;
  localparam int PosW   = 10;
  localparam int MaskW  = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 8;
  localparam int OutDataW = 32;

  // Divider sizing: sum magnitude up to 3 * 127, count up to 9
  localparam int MagW  = 9;
  localparam int CntW  = 4;
  localparam int RemW  = 4;
  localparam int DivSteps = MagW;
  localparam int StepW = 4;

  localparam int CentrePos = 127;

  // Key indexes
  localparam logic [KeyW-1:0] KEY_LAST_DIR = 4'd8;
  localparam logic [KeyW-1:0] KEY_BTN0     = 4'd9;
  localparam logic [KeyW-1:0] KEY_BTN1     = 4'd10;

  // Pad types
  localparam logic [TypeW-1:0] PAD_KEYBOARD  = 3'd2;
  localparam logic [TypeW-1:0] PAD_KB_CENTER = 3'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FIRST_PAD  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_PAD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TRIM_X     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TRIM_Y     = 2'd3;

  // Held arrow patterns {up, right, left, down} that select a fixed diagonal
  localparam logic [3:0] ARW_DOWN_LEFT  = 4'b0011;
  localparam logic [3:0] ARW_DOWN_RIGHT = 4'b0101;
  localparam logic [3:0] ARW_UP_LEFT    = 4'b1010;
  localparam logic [3:0] ARW_UP_RIGHT   = 4'b1100;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted beat, update held keys
    logic step;      // one divider iteration
    logic out_load;  // write the result into the output register
  } kje_cmd_t;

  function automatic logic is_keyboard(input logic [TypeW-1:0] t);
    return (t == PAD_KEYBOARD) || (t == PAD_KB_CENTER);
  endfunction

endpackage

// ----- hw/rtl/kje_ctrl.sv -----
// ----------------------------------------------------------------------------
// kje_ctrl
// Sequencer: accept a beat, run the divider, hand the result to the output
// register.
// ----------------------------------------------------------------------------
module kje_ctrl import kje_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output kje_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             oval_r, oval_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    oval_nxt     = oval_r;
    cmd          = '0;
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + StepW'(1);
        if (step_r == StepW'(DivSteps - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // output register free, or being emptied this cycle
        if (!oval_r || out_tready) begin
          cmd.out_load = 1'b1;
          oval_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// ----- hw/rtl/kje_dp.sv -----
// ----------------------------------------------------------------------------
// kje_dp
// Datapath: config registers, held-key flags, direction sums, a pair of
// restoring dividers and the output register.
// ----------------------------------------------------------------------------
module kje_dp import kje_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic [InDataW-1:0]  in_tdata,
  input  kje_cmd_t            cmd,
  output logic [OutDataW-1:0] out_tdata
);

  logic [TypeW-1:0]       pad1_r, pad2_r;
  logic signed [TrimW-1:0] trim_x_r, trim_y_r;
  logic [8:0]             held_r, held_nxt;

  // Beat fields
  logic [KeyW-1:0] key;
  logic            ext, down, rep;
  assign key  = in_tdata[3:0];
  assign ext  = in_tdata[4];
  assign down = in_tdata[5];
  assign rep  = in_tdata[6];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad1_r   <= '0;
      pad2_r   <= '0;
      trim_x_r <= '0;
      trim_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_PAD:  pad1_r   <= cfg_wdata[TypeW-1:0];
        REG_SECOND_PAD: pad2_r   <= cfg_wdata[TypeW-1:0];
        REG_TRIM_X:     trim_x_r <= cfg_wdata;
        REG_TRIM_Y:     trim_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Event decode
  logic pad_sel, centering, second_kb, is_dir, handled, pwrite;
  logic [MaskW-1:0] mask;
  logic level;

  assign pad_sel   = !is_keyboard(pad1_r);
  assign centering = ((pad_sel ? pad2_r : pad1_r) == PAD_KB_CENTER);
  assign second_kb = is_keyboard(pad2_r);
  assign handled   = !ext && (key <= KEY_BTN1);
  assign is_dir    = !ext && (key <= KEY_LAST_DIR);
  assign pwrite    = is_dir && ((down && !rep) || centering);

  always_comb begin
    mask = '0;
    if (handled && key == KEY_BTN0) begin
      mask = second_kb ? 3'd6 : 3'd1;
    end else if (handled && key == KEY_BTN1) begin
      mask = second_kb ? 3'd0 : 3'd2;
    end
    level = (mask != '0) && down;
  end

  // Held flags after this beat
  always_comb begin
    held_nxt = held_r;
    if (is_dir) begin
      held_nxt[key] = down;
    end
  end

  // Direction sums as sign and magnitude, and the held count
  logic [3:0]      arrows;
  logic [1:0]      n_l, n_r, n_d, n_u, mx, my;
  logic            sx, sy;
  logic [CntW-1:0] cnt;

  assign arrows = {held_nxt[7], held_nxt[5], held_nxt[3], held_nxt[1]};

  always_comb begin
    n_l = 2'(held_nxt[0]) + 2'(held_nxt[3]) + 2'(held_nxt[6]);
    n_r = 2'(held_nxt[2]) + 2'(held_nxt[5]) + 2'(held_nxt[8]);
    n_d = 2'(held_nxt[0]) + 2'(held_nxt[1]) + 2'(held_nxt[2]);
    n_u = 2'(held_nxt[6]) + 2'(held_nxt[7]) + 2'(held_nxt[8]);
    cnt = 4'(n_d) + 4'(n_u) + 4'(held_nxt[3]) + 4'(held_nxt[4]) + 4'(held_nxt[5]);
    sx  = n_l > n_r;
    mx  = sx ? n_l - n_r : n_r - n_l;
    // lower row counts toward +y
    sy  = n_u > n_d;
    my  = sy ? n_u - n_d : n_d - n_u;
    case (arrows)
      ARW_DOWN_LEFT:  begin sx = 1'b1; mx = 2'd1; sy = 1'b0; my = 2'd1; cnt = 4'd1; end
      ARW_DOWN_RIGHT: begin sx = 1'b0; mx = 2'd1; sy = 1'b0; my = 2'd1; cnt = 4'd1; end
      ARW_UP_LEFT:    begin sx = 1'b1; mx = 2'd1; sy = 1'b1; my = 2'd1; cnt = 4'd1; end
      ARW_UP_RIGHT:   begin sx = 1'b0; mx = 2'd1; sy = 1'b1; my = 2'd1; cnt = 4'd1; end
      default: ;
    endcase
    // nothing held: sum is zero, divide by one
    if (cnt == '0) begin
      cnt = 4'd1;
    end
  end

  // Divider state: dividend shifts out as quotient shifts in
  logic [MagW-1:0] qx_r, qy_r;
  logic [RemW-1:0] rx_r, ry_r;
  logic [CntW-1:0] dvs_r;
  logic            sx_r, sy_r;
  logic            handled_r, pwrite_r, pad_r, level_r;
  logic [MaskW-1:0] mask_r;

  logic [RemW:0] rx_sh, ry_sh;
  logic          gx, gy;

  assign rx_sh = {rx_r, qx_r[MagW-1]};
  assign ry_sh = {ry_r, qy_r[MagW-1]};
  assign gx    = rx_sh >= {1'b0, dvs_r};
  assign gy    = ry_sh >= {1'b0, dvs_r};

  // Held flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.load) begin
      held_r <= held_nxt;
    end
  end

  // Beat capture and division steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_r      <= {mx, 7'd0} - MagW'(mx);
      qy_r      <= {my, 7'd0} - MagW'(my);
      rx_r      <= '0;
      ry_r      <= '0;
      dvs_r     <= cnt;
      sx_r      <= sx;
      sy_r      <= sy;
      handled_r <= handled;
      pwrite_r  <= pwrite;
      pad_r     <= pad_sel;
      mask_r    <= mask;
      level_r   <= level;
    end else if (cmd.step) begin
      rx_r <= gx ? RemW'(rx_sh - {1'b0, dvs_r}) : rx_sh[RemW-1:0];
      ry_r <= gy ? RemW'(ry_sh - {1'b0, dvs_r}) : ry_sh[RemW-1:0];
      qx_r <= {qx_r[MagW-2:0], gx};
      qy_r <= {qy_r[MagW-2:0], gy};
    end
  end

  // Final position: signed quotient plus centre and trim
  logic signed [PosW:0] vx, vy, px, py;
  always_comb begin
    vx = sx_r ? -$signed({2'b00, qx_r}) : $signed({2'b00, qx_r});
    vy = sy_r ? -$signed({2'b00, qy_r}) : $signed({2'b00, qy_r});
    px = vx + (PosW+1)'(CentrePos) + (PosW+1)'(trim_x_r);
    py = vy + (PosW+1)'(CentrePos) + (PosW+1)'(trim_y_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= {5'd0, level_r, mask_r,
                    pwrite_r ? py[PosW-1:0] : '0,
                    pwrite_r ? px[PosW-1:0] : '0,
                    pad_r, pwrite_r, handled_r};
    end
  end

endmodule

// ----- hw/rtl/keypad_joystick_emulation.sv -----
// ----------------------------------------------------------------------------
// keypad_joystick_emulation
// Keypad key events in, emulated joystick position and button writes out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | beat
//  in_     | in  | tvalid / tready   | one key event
//  out_    | out | tvalid / tready   | one result per key event
//
//  cfg_    | in  | we (no wait)      | pad types and trims
//
// The accept edge captures the event. Nine divider iterations follow, one
// quotient bit each for the 9-bit sum magnitude, then the hold state loads
// the output register. No new event is taken until that load is done and
// the sequencer is idle again. A new event is accepted while the previous
// result waits in the output register; if that register is still full at
// the end of the division the sequencer holds. Reset (rst_n, synchronous)
// releases all keys and clears the config registers.
// ----------------------------------------------------------------------------
module keypad_joystick_emulation import kje_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // [3:0] key_index, [4] extended, [5] pressed, [6] autorepeat
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [0] handled, [1] position_write, [2] pad_number, [12:3] position_x,
  // [22:13] position_y, [25:23] button_write_mask, [26] button_level
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  kje_cmd_t cmd;

  kje_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  kje_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

endmodule
